@@ src/tre_pkg.sv @@
// Package for the threshold run encoder: frame limits, field widths,
// register index codes and gray constants. No dependencies.
package tre_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;

  // internal counter widths, derived from the frame limits
  localparam int ColW   = $clog2(MaxWidth + 1);
  localparam int StartW = $clog2(MaxWidth);
  localparam int RowW   = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  // fixed field widths of the stream payloads
  localparam int PixW      = 8;
  localparam int RunRowW   = 12;
  localparam int RunBeginW = 12;
  localparam int RunEndW   = 13;
  localparam int OutDataW  = 40;  // 37 field bits padded to whole bytes

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegLowerGray = 1'd0;
  localparam logic [CfgIdxW-1:0] RegUpperGray = 1'd1;

  localparam logic [PixW-1:0] GrayMin = 8'd0;
  localparam logic [PixW-1:0] GrayMax = 8'd255;

  localparam logic [PixW-1:0] LowerGrayRst = 8'd128;
  localparam logic [PixW-1:0] UpperGrayRst = 8'd255;

  typedef struct packed {
    logic [RunEndW-1:0]   run_end;
    logic [RunBeginW-1:0] run_begin;
    logic [RunRowW-1:0]   run_row;
  } run_t;

endpackage

@@ src/tre_classify.sv @@
// Foreground test of one pixel against the two gray limits.
// Depends on tre_pkg.
module tre_classify (
  input  logic [tre_pkg::PixW-1:0] pixel_i,
  input  logic [tre_pkg::PixW-1:0] lower_i,
  input  logic [tre_pkg::PixW-1:0] upper_i,
  output logic                     fg_o
);
  import tre_pkg::*;

  always_comb begin
    if (lower_i == GrayMin) begin
      fg_o = pixel_i < upper_i;            // dark mode
    end else if (upper_i == GrayMax) begin
      fg_o = pixel_i > lower_i;            // bright mode
    end else begin
      fg_o = (pixel_i > lower_i) && (pixel_i < upper_i);
    end
  end

endmodule

@@ src/threshold_run_encoder.sv @@
// Threshold run encoder: gray pixel stream in, foreground runs out.
// Depends on tre_pkg and tre_classify.
//
// Pixels come in raster order, one transaction per pixel, with tlast marking
// the last pixel of a row and tuser the last pixel of a frame (which also
// ends the row). Each maximal horizontal run of foreground pixels yields one
// output transaction carrying row, first column and exclusive end column; a
// run open at row end closes there. One pixel is taken every cycle: the
// foreground test and run bookkeeping sit between the state registers and
// the result register, and a one-entry skid stage behind the result register
// keeps input flowing while a result waits; the input stalls only when both
// are full. Columns from index MaxWidth on are ignored and rows past MaxHeight-1
// report that last row index. Limit writes take effect from the next pixel.
module threshold_run_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [tre_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tre_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,   // [7:0] pixel_value
  input  logic                             s_axis_tlast_i,   // row_last
  input  logic                             s_axis_tuser_i,   // frame_last
  // run stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tre_pkg::OutDataW-1:0]     m_axis_tdata_o    // [11:0] run_row,
                                                             // [23:12] run_begin,
                                                             // [36:24] run_end
);
  import tre_pkg::*;

  logic [PixW-1:0]   lower_q, upper_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic              open_q, open_d;
  logic [StartW-1:0] start_q, start_d;

  run_t out_q, skid_q, res;
  logic out_v_q, skid_v_q;

  logic fg, accept, in_row, row_end, open_mid, emit_mid, emit_end, emit;
  logic [ColW-1:0] end_col;
  logic [31:0]     row_ext, begin_ext, end_ext;

  tre_classify u_classify (
    .pixel_i (s_axis_tdata_i[PixW-1:0]),
    .lower_i (lower_q),
    .upper_i (upper_q),
    .fg_o    (fg)
  );

  assign s_axis_tready_o = !skid_v_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LowerGrayRst;
      upper_q <= UpperGrayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLowerGray: lower_q <= cfg_data_i[PixW-1:0];
        RegUpperGray: upper_q <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // run bookkeeping for the current pixel
  always_comb begin
    in_row   = col_q < ColW'(MaxWidth);
    row_end  = s_axis_tlast_i || s_axis_tuser_i;
    emit_mid = in_row && !fg && open_q;
    open_mid = (in_row && fg) ? 1'b1 : (emit_mid ? 1'b0 : open_q);
    start_d  = (in_row && fg && !open_q) ? col_q[StartW-1:0] : start_q;
    emit_end = row_end && open_mid;
    emit     = emit_mid || emit_end;
    open_d   = emit_end ? 1'b0 : open_mid;

    if (emit_end) begin
      end_col = in_row ? (col_q + ColW'(1)) : ColW'(MaxWidth);
    end else begin
      end_col = col_q;
    end

    if (row_end) begin
      col_d = '0;
    end else if (in_row) begin
      col_d = col_q + ColW'(1);
    end else begin
      col_d = col_q;
    end

    if (s_axis_tuser_i) begin
      row_d = '0;
    end else if (row_end && (32'(row_q) < 32'(MaxHeight - 1))) begin
      row_d = row_q + RowW'(1);
    end else begin
      row_d = row_q;
    end

    row_ext       = 32'(row_q);
    begin_ext     = 32'(start_d);
    end_ext       = 32'(end_col);
    res.run_row   = row_ext[RunRowW-1:0];
    res.run_begin = begin_ext[RunBeginW-1:0];
    res.run_end   = end_ext[RunEndW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      open_q  <= 1'b0;
      start_q <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      row_q   <= row_d;
      open_q  <= open_d;
      start_q <= start_d;
    end
  end

  // result register with skid stage; skid drains before new results
  logic out_free;
  assign out_free = !out_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_v_q  <= skid_v_q || (accept && emit);
        skid_v_q <= 1'b0;
      end else if (accept && emit) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end
    if (!out_free && accept && emit) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {{(OutDataW - RunRowW - RunBeginW - RunEndW){1'b0}},
                            out_q.run_end, out_q.run_begin, out_q.run_row};

endmodule

@@ sim/threshold_run_encoder_tb.sv @@
// Self-checking testbench for threshold_run_encoder: random pixel frames in,
// predicted foreground runs compared against the run stream.
// Depends on tre_pkg and the encoder RTL only.
module threshold_run_encoder_tb;
  import tre_pkg::*;

  localparam int QuietLimit = 1000;  // cycles with no transaction on either side

  // Tracks encoder state per accepted pixel and holds the runs still owed.
  class run_scoreboard;
    int unsigned lower_gray;
    int unsigned upper_gray;
    int unsigned col;
    int unsigned row;
    int unsigned start_col;
    bit          run_open;
    run_t        expected_runs[$];
    int          errors;

    function new();
      lower_gray = LowerGrayRst;
      upper_gray = UpperGrayRst;
      col        = 0;
      row        = 0;
      start_col  = 0;
      run_open   = 1'b0;
      errors     = 0;
    endfunction

    function void set_limit(logic [CfgIdxW-1:0] idx, int unsigned val);
      if (idx == RegLowerGray) lower_gray = val;
      else upper_gray = val;
    endfunction

    function bit is_fg(int unsigned pix);
      if (lower_gray == GrayMin) return pix < upper_gray;
      if (upper_gray == GrayMax) return pix > lower_gray;
      return (pix > lower_gray) && (pix < upper_gray);
    endfunction

    function void close_run(int unsigned end_col);
      run_t r;
      r.run_row   = row[RunRowW-1:0];
      r.run_begin = start_col[RunBeginW-1:0];
      r.run_end   = end_col[RunEndW-1:0];
      expected_runs.push_back(r);
      run_open = 1'b0;
    endfunction

    function void note_pixel(logic [PixW-1:0] pix, logic row_last, logic frame_last);
      int unsigned c;
      bit          in_row;
      bit          row_end;
      c       = col;
      in_row  = c < MaxWidth;
      row_end = row_last || frame_last;
      if (in_row) begin
        if (is_fg(pix)) begin
          if (!run_open) begin
            run_open  = 1'b1;
            start_col = c;
          end
        end else if (run_open) begin
          close_run(c);
        end
      end
      // pixels past the width limit are ignored, open run ends at the limit
      if (row_end && run_open) close_run(in_row ? c + 1 : MaxWidth);
      if (row_end) begin
        col = 0;
        if (frame_last) row = 0;
        else if (row < MaxHeight - 1) row++;
      end else if (in_row) begin
        col = c + 1;
      end
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        $error("unexpected run: row %0d begin %0d end %0d",
               got.run_row, got.run_begin, got.run_end);
        errors++;
        return;
      end
      want = expected_runs.pop_front();
      if (got.run_row !== want.run_row) begin
        $error("run_row: expected %0d, got %0d", want.run_row, got.run_row);
        errors++;
      end
      if (got.run_begin !== want.run_begin) begin
        $error("run_begin: expected %0d, got %0d", want.run_begin, got.run_begin);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = RegLowerGray;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;   // [7:0] pixel_value
  logic                s_tlast  = 1'b0; // row_last
  logic                s_tuser  = 1'b0; // frame_last
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;         // [11:0] run_row, [23:12] run_begin, [36:24] run_end

  run_scoreboard runs = new();
  bit            rush = 1'b0;  // no idling on either side while set
  int unsigned   quiet = 0;

  always #4 clk_i = ~clk_i;

  threshold_run_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  task automatic push_pixel(input logic [7:0] pix, input logic row_last,
                            input logic frame_last);
    int unsigned gap;
    gap = rush ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= row_last;
    s_tuser  <= frame_last;
    do @(posedge clk_i); while (!s_tready);
    runs.note_pixel(pix, row_last, frame_last);
  endtask

  // drop valid and let the pipeline drain before touching the limits
  task automatic load_limits(input int unsigned lo, input int unsigned hi);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (runs.expected_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegLowerGray;
    cfg_data <= lo[CfgDataW-1:0];
    runs.set_limit(RegLowerGray, lo);
    @(negedge clk_i);
    cfg_idx  <= RegUpperGray;
    cfg_data <= hi[CfgDataW-1:0];
    runs.set_limit(RegUpperGray, hi);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // run stream receiver
  initial begin
    int unsigned stall;
    forever begin
      stall = rush ? 0 : $urandom_range(0, 18);
      repeat (stall) begin
        @(negedge clk_i);
        m_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      runs.check_run(run_t'(m_tdata[RunEndW+RunBeginW+RunRowW-1:0]));
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("threshold_run_encoder_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned lo_tab[8] = '{0,   0,   255, 1,   0, 254, 100, 127};
    int unsigned hi_tab[8] = '{0,   255, 255, 254, 1, 255, 100, 129};
    int unsigned cols_left;
    int unsigned rows_left;
    logic [7:0]  pix;
    logic [7:0]  prev;
    logic        rl;
    logic        fl;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: bright mode, foreground above 128
    push_pixel(8'd0,   1'b0, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd129, 1'b0, 1'b0);
    push_pixel(8'd128, 1'b0, 1'b0);
    push_pixel(8'd200, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b1, 1'b0);  // run open at row end
    push_pixel(8'd255, 1'b1, 1'b0);  // one-pixel row
    push_pixel(8'd129, 1'b0, 1'b0);
    push_pixel(8'd0,   1'b0, 1'b1);  // frame end without row end
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b1);  // frame end closes the open run
    push_pixel(8'd0,   1'b1, 1'b1);

    cols_left = 0;
    rows_left = 0;
    prev      = '0;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase < 8) load_limits(lo_tab[phase], hi_tab[phase]);
      else if (phase > 8) load_limits($urandom_range(0, 255), $urandom_range(0, 255));
      for (int n = 0; n < 135; n++) begin
        if ($urandom_range(0, 39) == 0) rush = !rush;
        case ($urandom_range(0, 7))
          0:       pix = $urandom_range(0, 1) ? GrayMax : GrayMin;
          1:       pix = 8'(runs.lower_gray + $urandom_range(0, 2) - 1);
          2:       pix = 8'(runs.upper_gray + $urandom_range(0, 2) - 1);
          3, 4, 5: pix = prev;
          default: pix = $urandom_range(0, 255);
        endcase
        prev = pix;
        if (rows_left == 0) rows_left = $urandom_range(1, 6);
        if (cols_left == 0)
          cols_left = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 300)
                                                   : $urandom_range(1, 24);
        // occasional frame cut short mid-row
        if ($urandom_range(0, 79) == 0) begin
          cols_left = 1;
          rows_left = 1;
        end
        rl = (cols_left == 1);
        fl = 1'b0;
        if (rl && rows_left == 1) begin
          fl = 1'b1;
          rl = ($urandom_range(0, 3) != 0);
        end
        push_pixel(pix, rl, fl);
        cols_left--;
        if (cols_left == 0) rows_left--;
      end
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (runs.expected_runs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (runs.errors == 0) $display("threshold_run_encoder_tb: PASS");
    else $display("threshold_run_encoder_tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/tre_pkg.sv
src/tre_classify.sv
src/threshold_run_encoder.sv
sim/threshold_run_encoder_tb.sv
